>>> hw/rtl/sar_pkg.sv
// ----------------------------------------------------------------------------
// sar_pkg
// types and constants shared by the shortest-arc rotation block
// ----------------------------------------------------------------------------
package sar_pkg;

  localparam int unsigned VEC_W       = 24;
  localparam int unsigned Q_W         = 32;
  localparam int unsigned MIN_NORM_W  = 23;
  localparam int unsigned MARGIN_W    = 31;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 31;
  localparam int unsigned NORM2_W     = 48;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_NORM = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MARGIN   = 2'd1;

  localparam logic [MIN_NORM_W-1:0] MIN_NORM_RESET = 23'd102;
  localparam logic [MARGIN_W-1:0]   MARGIN_RESET   = 31'd16;

  // result kinds
  localparam logic [1:0] CASE_IDENTITY  = 2'd0;
  localparam logic [1:0] CASE_GENERAL   = 2'd1;
  localparam logic [1:0] CASE_HALF_TURN = 2'd2;

  localparam logic signed [Q_W-1:0] ONE_Q30 = 32'sh4000_0000;

  typedef struct packed {
    logic signed [VEC_W-1:0] from_x;
    logic signed [VEC_W-1:0] from_y;
    logic signed [VEC_W-1:0] from_z;
    logic signed [VEC_W-1:0] to_x;
    logic signed [VEC_W-1:0] to_y;
    logic signed [VEC_W-1:0] to_z;
  } sar_in_t;

  typedef struct packed {
    logic signed [Q_W-1:0] quat_w;
    logic signed [Q_W-1:0] quat_x;
    logic signed [Q_W-1:0] quat_y;
    logic signed [Q_W-1:0] quat_z;
    logic [1:0]            case_taken;
  } sar_out_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [2:0][VEC_W-1:0] src;
    logic [2:0][VEC_W-1:0] dst;
    logic [NORM2_W-1:0]    src_n2;
    logic [NORM2_W-1:0]    dst_n2;
    logic                  short_vec;
  } sar_item_t;

endpackage

>>> hw/rtl/sar_isqrt.sv
// ----------------------------------------------------------------------------
// sar_isqrt
// pipelined floor square root, one root bit per stage, several lanes
// ----------------------------------------------------------------------------
module sar_isqrt #(
  parameter int unsigned LANES = 1,
  parameter int unsigned RW    = 32,
  parameter int unsigned TW    = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [LANES-1:0][2*RW-1:0]     in_x,
  input  logic [TW-1:0]                  in_tag,
  output logic                           out_valid,
  output logic [LANES-1:0][RW-1:0]       out_root,
  output logic [TW-1:0]                  out_tag
);

  localparam int unsigned XW = 2 * RW;
  localparam int unsigned EW = RW + 3;

  logic [RW-1:0]                 vld;
  logic [LANES-1:0][XW-1:0]      xs        [RW];
  logic [LANES-1:0][RW:0]        rem       [RW];
  logic [LANES-1:0][RW-1:0]      root      [RW];
  logic [TW-1:0]                 tag       [RW];
  logic [LANES-1:0][XW-1:0]      xs_next   [RW];
  logic [LANES-1:0][RW:0]        rem_next  [RW];
  logic [LANES-1:0][RW-1:0]      root_next [RW];
  logic [TW-1:0]                 tag_next  [RW];

  always_comb begin
    logic [XW-1:0] sx;
    logic [RW:0]   srem;
    logic [RW-1:0] sroot;
    logic [EW-1:0] cur;
    logic [EW-1:0] trial;
    logic [EW-1:0] diff;
    for (int k = 0; k < RW; k++) begin
      tag_next[k] = (k == 0) ? in_tag : tag[(k == 0) ? 0 : k-1];
      for (int l = 0; l < LANES; l++) begin
        if (k == 0) begin
          sx    = in_x[l];
          srem  = '0;
          sroot = '0;
        end else begin
          sx    = xs[k-1][l];
          srem  = rem[k-1][l];
          sroot = root[k-1][l];
        end
        cur   = {srem, sx[XW-1 -: 2]};
        trial = {1'b0, sroot, 2'b01};
        diff  = cur - trial;
        xs_next[k][l] = {sx[XW-3:0], 2'b00};
        if (cur >= trial) begin
          rem_next[k][l]  = diff[RW:0];
          root_next[k][l] = {sroot[RW-2:0], 1'b1};
        end else begin
          rem_next[k][l]  = cur[RW:0];
          root_next[k][l] = {sroot[RW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[RW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < RW; k++) begin
        xs[k]   <= xs_next[k];
        rem[k]  <= rem_next[k];
        root[k] <= root_next[k];
        tag[k]  <= tag_next[k];
      end
    end
  end

  assign out_valid = vld[RW-1];
  assign out_root  = root[RW-1];
  assign out_tag   = tag[RW-1];

endmodule

>>> hw/rtl/sar_div.sv
// ----------------------------------------------------------------------------
// sar_div
// pipelined rounded divider, one quotient bit per stage, several lanes
// ----------------------------------------------------------------------------
module sar_div #(
  parameter int unsigned LANES = 1,
  parameter int unsigned NW    = 62,
  parameter int unsigned DW    = 32,
  parameter int unsigned QW    = 32,
  parameter int unsigned TW    = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [LANES-1:0][NW-1:0]   in_mag,
  input  logic [LANES-1:0][DW-1:0]   in_den,
  input  logic [TW-1:0]              in_tag,
  output logic                       out_valid,
  output logic [LANES-1:0][QW-1:0]   out_quo,
  output logic [TW-1:0]              out_tag
);

  // caller keeps the rounded quotient below 2^QW
  localparam int unsigned CW = (NW > DW + QW) ? NW : DW + QW;

  logic [QW-1:0]                vld;
  logic [LANES-1:0][NW-1:0]     rem      [QW];
  logic [LANES-1:0][DW-1:0]     den      [QW];
  logic [LANES-1:0][QW-1:0]     quo      [QW];
  logic [TW-1:0]                tag      [QW];
  logic [LANES-1:0][NW-1:0]     rem_next [QW];
  logic [LANES-1:0][DW-1:0]     den_next [QW];
  logic [LANES-1:0][QW-1:0]     quo_next [QW];
  logic [TW-1:0]                tag_next [QW];

  always_comb begin
    logic [NW-1:0] srem;
    logic [DW-1:0] sden;
    logic [QW-1:0] squo;
    logic [CW-1:0] dsh;
    logic [CW-1:0] diff;
    for (int k = 0; k < QW; k++) begin
      tag_next[k] = (k == 0) ? in_tag : tag[(k == 0) ? 0 : k-1];
      for (int l = 0; l < LANES; l++) begin
        if (k == 0) begin
          // half the divisor added up front gives round to nearest
          srem = in_mag[l] + NW'(in_den[l] >> 1);
          sden = in_den[l];
          squo = '0;
        end else begin
          srem = rem[k-1][l];
          sden = den[k-1][l];
          squo = quo[k-1][l];
        end
        dsh  = CW'(sden) << (QW - 1 - k);
        diff = CW'(srem) - dsh;
        den_next[k][l] = sden;
        if (CW'(srem) >= dsh) begin
          rem_next[k][l] = diff[NW-1:0];
          quo_next[k][l] = squo | (QW'(1) << (QW - 1 - k));
        end else begin
          rem_next[k][l] = srem;
          quo_next[k][l] = squo;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem[k] <= rem_next[k];
        den[k] <= den_next[k];
        quo[k] <= quo_next[k];
        tag[k] <= tag_next[k];
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign out_quo   = quo[QW-1];
  assign out_tag   = tag[QW-1];

endmodule

>>> hw/rtl/sar_front.sv
// ----------------------------------------------------------------------------
// sar_front
// accepts vector pairs, squares the lengths and flags short vectors
// ----------------------------------------------------------------------------
module sar_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [sar_pkg::MIN_NORM_W-1:0]      min_norm,
  input  logic                                vec_valid,
  output logic                                vec_stall,
  input  sar_pkg::sar_in_t                    vec,
  output logic                                push,
  output sar_pkg::sar_item_t                  push_data,
  input  logic                                full
);

  function automatic logic [46:0] sqr(input logic signed [23:0] v);
    logic signed [47:0] p;
    p = v * v;
    return p[46:0];
  endfunction

  logic [45:0]            lim;
  logic                   adv;
  logic                   va;
  logic                   vb;
  logic [2:0][23:0]       sa;
  logic [2:0][23:0]       da;
  logic [2:0][46:0]       sq_s;
  logic [2:0][46:0]       sq_d;
  logic [47:0]            n2_s;
  logic [47:0]            n2_d;
  sar_pkg::sar_item_t     item_b;

  assign adv       = !(vb && full);
  assign vec_stall = !adv;

  always_ff @(posedge clk) begin
    lim <= 46'(min_norm) * 46'(min_norm);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (adv) begin
      va <= vec_valid;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa      <= {vec.from_z, vec.from_y, vec.from_x};
      da      <= {vec.to_z, vec.to_y, vec.to_x};
      sq_s[0] <= sqr(vec.from_x);
      sq_s[1] <= sqr(vec.from_y);
      sq_s[2] <= sqr(vec.from_z);
      sq_d[0] <= sqr(vec.to_x);
      sq_d[1] <= sqr(vec.to_y);
      sq_d[2] <= sqr(vec.to_z);
    end
  end

  assign n2_s = {1'b0, sq_s[0]} + {1'b0, sq_s[1]} + {1'b0, sq_s[2]};
  assign n2_d = {1'b0, sq_d[0]} + {1'b0, sq_d[1]} + {1'b0, sq_d[2]};

  always_ff @(posedge clk) begin
    if (adv) begin
      item_b.src       <= sa;
      item_b.dst       <= da;
      item_b.src_n2    <= n2_s;
      item_b.dst_n2    <= n2_d;
      item_b.short_vec <= (n2_s == '0) || (n2_d == '0) ||
                          (n2_s < {2'b00, lim}) || (n2_d < {2'b00, lim});
    end
  end

  assign push      = vb && !full;
  assign push_data = item_b;

endmodule

>>> hw/rtl/sar_queue.sv
// ----------------------------------------------------------------------------
// sar_queue
// short request queue between front and back
// ----------------------------------------------------------------------------
module sar_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sar_pkg::sar_item_t   push_data,
  output logic                 full,
  input  logic                 pop,
  output sar_pkg::sar_item_t   pop_data,
  output logic                 avail
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sar_pkg::sar_item_t slot [DEPTH];
  logic [AW-1:0]      wr_ptr;
  logic [AW-1:0]      rd_ptr;
  logic [AW:0]        count;

  function automatic logic [AW-1:0] step(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (count == (AW+1)'(DEPTH));
  assign avail    = (count != '0);
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= step(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= step(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hw/rtl/sar_back.sv
// ----------------------------------------------------------------------------
// sar_back
// unit vectors, dot and cross, case choice and final normalisation
// ----------------------------------------------------------------------------
module sar_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [sar_pkg::MARGIN_W-1:0]      margin,
  input  logic                              avail,
  input  sar_pkg::sar_item_t                item,
  output logic                              pop,
  output logic                              quat_valid,
  input  logic                              quat_stall,
  output sar_pkg::sar_out_t                 quat
);

  typedef struct packed {
    logic             short_vec;
    logic [2:0][23:0] src;
    logic [2:0][23:0] dst;
  } root_tag_t;

  typedef struct packed {
    logic       short_vec;
    logic [5:0] neg;
  } unit_tag_t;

  typedef struct packed {
    logic             short_vec;
    logic [1:0]       kind;
    logic [3:0][32:0] p;
  } norm_tag_t;

  typedef struct packed {
    logic       short_vec;
    logic [1:0] kind;
    logic       zero;
    logic [3:0] neg;
  } scale_tag_t;

  function automatic logic [23:0] abs24(input logic [23:0] v);
    return v[23] ? 24'(-v) : v;
  endfunction

  function automatic logic signed [31:0] clamp_q(input logic [31:0] q, input logic neg);
    logic [31:0] m;
    m = (q > 32'h4000_0000) ? 32'h4000_0000 : q;
    return neg ? 32'(-m) : m;
  endfunction

  // round half away from zero of v / 2^30, clamped to one
  function automatic logic signed [31:0] rnd30(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] q;
    mag = v[63] ? 64'(-v) : v;
    q   = (mag + 64'h2000_0000) >> 30;
    if (q > 64'h4000_0000) begin
      q = 64'h4000_0000;
    end
    return v[63] ? 32'(-q[31:0]) : q[31:0];
  endfunction

  function automatic logic [63:0] sq33(input logic signed [32:0] v);
    logic signed [65:0] t;
    t = v * v;
    return t[63:0];
  endfunction

  logic en;
  assign en  = !(quat_valid && quat_stall);
  assign pop = en && avail;

  // lengths of both vectors
  logic [1:0][63:0]  r1_x;
  root_tag_t         r1_tag_in;
  root_tag_t         r1_tag;
  logic              r1_valid;
  logic [1:0][31:0]  r1_root;

  assign r1_x[0]   = {item.src_n2, 16'h0000};
  assign r1_x[1]   = {item.dst_n2, 16'h0000};
  assign r1_tag_in = '{short_vec: item.short_vec, src: item.src, dst: item.dst};

  sar_isqrt #(.LANES(2), .RW(32), .TW($bits(root_tag_t))) u_len (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (avail),
    .in_x      (r1_x),
    .in_tag    (r1_tag_in),
    .out_valid (r1_valid),
    .out_root  (r1_root),
    .out_tag   (r1_tag)
  );

  // unit vectors
  logic [5:0][61:0]  d1_mag;
  logic [5:0][31:0]  d1_den;
  unit_tag_t         d1_tag_in;
  unit_tag_t         d1_tag;
  logic              d1_valid;
  logic [5:0][31:0]  d1_quo;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d1_mag[i]     = {abs24(r1_tag.src[i]), 38'h0};
      d1_mag[i+3]   = {abs24(r1_tag.dst[i]), 38'h0};
      d1_den[i]     = r1_root[0];
      d1_den[i+3]   = r1_root[1];
      d1_tag_in.neg[i]   = r1_tag.src[i][23];
      d1_tag_in.neg[i+3] = r1_tag.dst[i][23];
    end
    d1_tag_in.short_vec = r1_tag.short_vec;
  end

  sar_div #(.LANES(6), .NW(62), .DW(32), .QW(32), .TW($bits(unit_tag_t))) u_unit (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (r1_valid),
    .in_mag    (d1_mag),
    .in_den    (d1_den),
    .in_tag    (d1_tag_in),
    .out_valid (d1_valid),
    .out_quo   (d1_quo),
    .out_tag   (d1_tag)
  );

  // m1: clamped unit vectors
  logic               v_m1, sh_m1;
  logic signed [31:0] uu [3];
  logic signed [31:0] vv [3];

  // m2: products
  logic               v_m2, sh_m2;
  logic signed [31:0] u_m2 [3];
  logic signed [63:0] dp [3];
  logic signed [63:0] cp [6];

  // m3: dot and cross
  logic               v_m3, sh_m3;
  logic signed [31:0] u_m3 [3];
  logic signed [31:0] dot_m3;
  logic signed [31:0] cr_m3 [3];
  logic signed [63:0] dsum;

  // m4: case choice
  logic               v_m4, sh_m4;
  logic [1:0]         kind_m4;
  logic signed [32:0] p_m4 [4];
  logic signed [32:0] thresh;
  logic               anti;
  logic [30:0]        mu [3];
  logic signed [32:0] ue [3];

  // m5, m6: squared length
  logic               v_m5, sh_m5, v_m6, sh_m6;
  logic [1:0]         kind_m5, kind_m6;
  logic signed [32:0] p_m5 [4];
  logic signed [32:0] p_m6 [4];
  logic [63:0]        sq_m5 [4];
  logic [63:0]        ssum_m6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_m1 <= 1'b0;
      v_m2 <= 1'b0;
      v_m3 <= 1'b0;
      v_m4 <= 1'b0;
      v_m5 <= 1'b0;
      v_m6 <= 1'b0;
    end else if (en) begin
      v_m1 <= d1_valid;
      v_m2 <= v_m1;
      v_m3 <= v_m2;
      v_m4 <= v_m3;
      v_m5 <= v_m4;
      v_m6 <= v_m5;
    end
  end

  assign dsum   = dp[0] + dp[1] + dp[2];
  assign thresh = $signed({2'b00, margin}) - 33'sh0_4000_0000;
  assign anti   = $signed({dot_m3[31], dot_m3}) < thresh;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ue[i] = {u_m3[i][31], u_m3[i]};
      mu[i] = u_m3[i][31] ? 31'(-u_m3[i]) : u_m3[i][30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sh_m1 <= d1_tag.short_vec;
      for (int i = 0; i < 3; i++) begin
        uu[i] <= clamp_q(d1_quo[i], d1_tag.neg[i]);
        vv[i] <= clamp_q(d1_quo[i+3], d1_tag.neg[i+3]);
      end

      sh_m2 <= sh_m1;
      for (int i = 0; i < 3; i++) begin
        u_m2[i] <= uu[i];
        dp[i]   <= uu[i] * vv[i];
      end
      cp[0] <= uu[1] * vv[2];
      cp[1] <= uu[2] * vv[1];
      cp[2] <= uu[2] * vv[0];
      cp[3] <= uu[0] * vv[2];
      cp[4] <= uu[0] * vv[1];
      cp[5] <= uu[1] * vv[0];

      sh_m3    <= sh_m2;
      u_m3     <= u_m2;
      dot_m3   <= rnd30(dsum);
      cr_m3[0] <= rnd30(cp[0] - cp[1]);
      cr_m3[1] <= rnd30(cp[2] - cp[3]);
      cr_m3[2] <= rnd30(cp[4] - cp[5]);

      sh_m4 <= sh_m3;
      if (anti) begin
        // half turn about u crossed with the axis of its smallest component
        kind_m4 <= sar_pkg::CASE_HALF_TURN;
        p_m4[0] <= '0;
        if (mu[0] <= mu[1] && mu[0] <= mu[2]) begin
          p_m4[1] <= '0;
          p_m4[2] <= ue[2];
          p_m4[3] <= -ue[1];
        end else if (mu[1] <= mu[2]) begin
          p_m4[1] <= -ue[2];
          p_m4[2] <= '0;
          p_m4[3] <= ue[0];
        end else begin
          p_m4[1] <= ue[1];
          p_m4[2] <= -ue[0];
          p_m4[3] <= '0;
        end
      end else begin
        kind_m4 <= sar_pkg::CASE_GENERAL;
        p_m4[0] <= 33'sh0_4000_0000 + {dot_m3[31], dot_m3};
        p_m4[1] <= {cr_m3[0][31], cr_m3[0]};
        p_m4[2] <= {cr_m3[1][31], cr_m3[1]};
        p_m4[3] <= {cr_m3[2][31], cr_m3[2]};
      end

      sh_m5   <= sh_m4;
      kind_m5 <= kind_m4;
      p_m5    <= p_m4;
      for (int i = 0; i < 4; i++) begin
        sq_m5[i] <= sq33(p_m4[i]);
      end

      sh_m6   <= sh_m5;
      kind_m6 <= kind_m5;
      p_m6    <= p_m5;
      ssum_m6 <= sq_m5[0] + sq_m5[1] + sq_m5[2] + sq_m5[3];
    end
  end

  // length of the quaternion or axis
  logic [0:0][63:0] r2_x;
  logic [0:0][31:0] r2_root;
  norm_tag_t        r2_tag_in;
  norm_tag_t        r2_tag;
  logic             r2_valid;

  always_comb begin
    r2_x[0]             = ssum_m6;
    r2_tag_in.short_vec = sh_m6;
    r2_tag_in.kind      = kind_m6;
    for (int i = 0; i < 4; i++) begin
      r2_tag_in.p[i] = p_m6[i];
    end
  end

  sar_isqrt #(.LANES(1), .RW(32), .TW($bits(norm_tag_t))) u_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_m6),
    .in_x      (r2_x),
    .in_tag    (r2_tag_in),
    .out_valid (r2_valid),
    .out_root  (r2_root),
    .out_tag   (r2_tag)
  );

  // scaling to unit length
  logic [3:0][62:0] d2_mag;
  logic [3:0][31:0] d2_den;
  logic [3:0][31:0] d2_quo;
  logic [32:0]      pa;
  scale_tag_t       d2_tag_in;
  scale_tag_t       d2_tag;
  logic             d2_valid;

  always_comb begin
    pa = '0;
    for (int i = 0; i < 4; i++) begin
      pa = r2_tag.p[i][32] ? 33'(-r2_tag.p[i]) : r2_tag.p[i];
      d2_mag[i]        = {1'b0, pa[31:0], 30'h0};
      d2_den[i]        = r2_root[0];
      d2_tag_in.neg[i] = r2_tag.p[i][32];
    end
    d2_tag_in.short_vec = r2_tag.short_vec;
    d2_tag_in.kind      = r2_tag.kind;
    d2_tag_in.zero      = (r2_root[0] == '0);
  end

  sar_div #(.LANES(4), .NW(63), .DW(32), .QW(32), .TW($bits(scale_tag_t))) u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (r2_valid),
    .in_mag    (d2_mag),
    .in_den    (d2_den),
    .in_tag    (d2_tag_in),
    .out_valid (d2_valid),
    .out_quo   (d2_quo),
    .out_tag   (d2_tag)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      quat_valid <= 1'b0;
    end else if (en) begin
      quat_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (d2_tag.short_vec) begin
        quat.quat_w     <= sar_pkg::ONE_Q30;
        quat.quat_x     <= '0;
        quat.quat_y     <= '0;
        quat.quat_z     <= '0;
        quat.case_taken <= sar_pkg::CASE_IDENTITY;
      end else if (d2_tag.zero) begin
        // degenerate length: identity, or half turn about x
        quat.case_taken <= d2_tag.kind;
        quat.quat_y     <= '0;
        quat.quat_z     <= '0;
        if (d2_tag.kind == sar_pkg::CASE_HALF_TURN) begin
          quat.quat_w <= '0;
          quat.quat_x <= sar_pkg::ONE_Q30;
        end else begin
          quat.quat_w <= sar_pkg::ONE_Q30;
          quat.quat_x <= '0;
        end
      end else begin
        quat.quat_w     <= clamp_q(d2_quo[0], d2_tag.neg[0]);
        quat.quat_x     <= clamp_q(d2_quo[1], d2_tag.neg[1]);
        quat.quat_y     <= clamp_q(d2_quo[2], d2_tag.neg[2]);
        quat.quat_z     <= clamp_q(d2_quo[3], d2_tag.neg[3]);
        quat.case_taken <= d2_tag.kind;
      end
    end
  end

endmodule

>>> hw/rtl/shortest_arc_rotation.sv
// ----------------------------------------------------------------------------
// shortest_arc_rotation
// throughput: one request per cycle while no result is stalled, set by the
//   fully pipelined root and divider units (one result bit per stage)
// reset: synchronous, clears all valid state and loads the register defaults
// ----------------------------------------------------------------------------
module shortest_arc_rotation #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // vector pair requests
  input  logic                                 vec_valid,
  output logic                                 vec_stall,
  input  sar_pkg::sar_in_t                     vec,
  // rotation results
  output logic                                 quat_valid,
  input  logic                                 quat_stall,
  output sar_pkg::sar_out_t                    quat,
  // register writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sar_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [sar_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // configuration registers; the user writes them only while the block is idle (not enforced)
  logic [sar_pkg::MIN_NORM_W-1:0] min_norm;
  logic [sar_pkg::MARGIN_W-1:0]   margin;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_norm <= sar_pkg::MIN_NORM_RESET;
      margin   <= sar_pkg::MARGIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sar_pkg::CFG_MIN_NORM: min_norm <= cfg_data[sar_pkg::MIN_NORM_W-1:0];
        sar_pkg::CFG_MARGIN:   margin   <= cfg_data;
        default:               ;
      endcase
    end
  end

  // front: squared lengths and the short vector check, two stages
  logic               push;
  logic               full;
  logic               pop;
  logic               avail;
  sar_pkg::sar_item_t push_data;
  sar_pkg::sar_item_t pop_data;

  sar_front u_front (
    .clk       (clk),
    .rst       (rst),
    .min_norm  (min_norm),
    .vec_valid (vec_valid),
    .vec_stall (vec_stall),
    .vec       (vec),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  // queue decouples the front from stalls in the back
  sar_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .avail     (avail)
  );

  // back: unit vectors, dot and cross, case choice, normalisation;
  // the whole back pipeline holds while a finished result is stalled
  sar_back u_back (
    .clk        (clk),
    .rst        (rst),
    .margin     (margin),
    .avail      (avail),
    .item       (pop_data),
    .pop        (pop),
    .quat_valid (quat_valid),
    .quat_stall (quat_stall),
    .quat       (quat)
  );

endmodule

>>> hw/rtl/sar_checker.sv
// ----------------------------------------------------------------------------
// sar_checker
// port level checks on the rotation results
// ----------------------------------------------------------------------------
module sar_checker (
  input logic              clk,
  input logic              rst,
  input logic              quat_valid,
  input logic              quat_stall,
  input sar_pkg::sar_out_t quat
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    quat_valid && quat_stall |=> quat_valid && $stable(quat))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk)
    rst |=> !quat_valid)
    else $error("result valid after reset");

  a_identity: assert property (@(posedge clk) disable iff (rst)
    quat_valid && quat.case_taken == sar_pkg::CASE_IDENTITY |->
      quat.quat_w == sar_pkg::ONE_Q30 && quat.quat_x == '0 &&
      quat.quat_y == '0 && quat.quat_z == '0)
    else $error("short vector result is not the identity");

  a_half_turn: assert property (@(posedge clk) disable iff (rst)
    quat_valid && quat.case_taken == sar_pkg::CASE_HALF_TURN |-> quat.quat_w == '0)
    else $error("half turn with nonzero scalar part");

  a_general: assert property (@(posedge clk) disable iff (rst)
    quat_valid && quat.case_taken == sar_pkg::CASE_GENERAL |-> !quat.quat_w[31])
    else $error("general case with negative scalar part");

endmodule

bind shortest_arc_rotation sar_checker u_sar_checker (
  .clk        (clk),
  .rst        (rst),
  .quat_valid (quat_valid),
  .quat_stall (quat_stall),
  .quat       (quat)
);
